[hdl/apcc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package apcc_pkg;

    // Field widths
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned REGION_W = 31;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = REGION_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR   = 1'b1;

    // Reset values
    localparam logic [BYTE_W-1:0] SEP_RESET = 8'hEF;
    // Position of the first word start before any byte: byte address 0 minus 3
    localparam logic [WORD_W-1:0] POS_INIT  = 32'hFFFF_FFFD;

    typedef enum logic [1:0] {
        ST_CLEAN      = 2'd0,
        ST_MISALIGNED = 2'd1,
        ST_CORRUPT    = 2'd2
    } t_status;

    typedef enum logic [KIND_W-1:0] {
        EV_SEG_END  = 2'd0,
        EV_MISALIGN = 2'd1,
        EV_CORRUPT  = 2'd2
    } t_ev_kind;

    typedef struct packed {
        t_ev_kind            kind;
        logic [WORD_W-1:0]   position;
        logic [WORD_W-1:0]   value;
    } t_event;

endpackage

`default_nettype wire

[hdl/apcc_check.sv]
`timescale 1ns / 1ps
`default_nettype none

module apcc_check (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    input  wire [apcc_pkg::BYTE_W-1:0]   i_data,
    input  wire                          i_first,
    input  wire [apcc_pkg::REGION_W-1:0] i_region_size,
    input  wire [apcc_pkg::BYTE_W-1:0]   i_sep_byte,
    output logic                         o_ev_valid,
    output apcc_pkg::t_event             o_ev
);
    import apcc_pkg::*;

    // Running state
    logic [WORD_W-1:0] r_acc,  n_acc;
    logic [1:0]        r_biw,  n_biw;
    logic [1:0]        r_run,  n_run;
    t_status           r_status, n_status;
    logic [WORD_W-1:0] r_pos,  n_pos;   // address of current byte minus 3
    logic [WORD_W-1:0] r_exp,  n_exp;   // offset plus pos

    // State as seen by this beat (cleared on a first byte)
    logic [WORD_W-1:0] acc_e, pos_e, exp_e, acc_new;
    logic [1:0]        biw_e, run_e;
    t_status           status_e;
    logic              is_sep, sep_done, word_done, mismatch;
    logic              misalign, corrupt, seg_end;

    always_comb begin
        acc_e    = i_first ? '0 : r_acc;
        biw_e    = i_first ? 2'd0 : r_biw;
        run_e    = i_first ? 2'd0 : r_run;
        status_e = i_first ? ST_CLEAN : r_status;
        pos_e    = i_first ? POS_INIT : r_pos;
        exp_e    = i_first ? POS_INIT : r_exp;
    end

    // Byte merge, little endian
    always_comb begin
        acc_new = acc_e;
        acc_new[{biw_e, 3'b000} +: BYTE_W] = i_data;
    end

    // Separator run and word compare
    always_comb begin
        is_sep    = (i_data == i_sep_byte);
        sep_done  = is_sep && (run_e == 2'd3);
        word_done = !sep_done && (biw_e == 2'd3);
        mismatch  = word_done && (acc_new != exp_e);
        misalign  = mismatch && (status_e == ST_CLEAN) && (acc_new < {1'b0, i_region_size});
        corrupt   = mismatch && !misalign && (status_e != ST_CORRUPT);
        seg_end   = sep_done && (status_e == ST_CORRUPT);
    end

    // Next state
    always_comb begin
        n_run = is_sep ? (sep_done ? 2'd0 : run_e + 2'd1) : 2'd0;
        n_biw = (sep_done || word_done) ? 2'd0 : biw_e + 2'd1;
        n_acc = (sep_done || word_done) ? '0 : acc_new;
        n_pos = pos_e + 32'd1;
        n_exp = misalign ? acc_new + 32'd1 : exp_e + 32'd1;
        if (sep_done) begin
            n_status = ST_CLEAN;
        end else if (misalign) begin
            n_status = ST_MISALIGNED;
        end else if (corrupt) begin
            n_status = ST_CORRUPT;
        end else begin
            n_status = status_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_biw    <= 2'd0;
            r_run    <= 2'd0;
            r_status <= ST_CLEAN;
            r_pos    <= POS_INIT;
            r_exp    <= POS_INIT;
        end else if (i_valid) begin
            r_acc    <= n_acc;
            r_biw    <= n_biw;
            r_run    <= n_run;
            r_status <= n_status;
            r_pos    <= n_pos;
            r_exp    <= n_exp;
        end
    end

    // Event out
    always_comb begin
        o_ev_valid  = i_valid && (seg_end || misalign || corrupt);
        o_ev.position = pos_e;
        o_ev.value    = seg_end ? '0 : acc_new;
        if (seg_end) begin
            o_ev.kind = EV_SEG_END;
        end else if (misalign) begin
            o_ev.kind = EV_MISALIGN;
        end else begin
            o_ev.kind = EV_CORRUPT;
        end
    end

    // Checks
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> $onehot0({seg_end, misalign, corrupt}))
        else $error("more than one event kind in one beat");

    a_sep_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && sep_done |=> r_status == ST_CLEAN && r_biw == 2'd0)
        else $error("separator did not restart the segment");

    a_realign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && misalign |=> r_exp == $past(acc_new) + 32'd1)
        else $error("expected word not rebased after misalignment");

    a_no_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && corrupt |=> r_status == ST_CORRUPT)
        else $error("corrupt status not held");

endmodule

`default_nettype wire

[hdl/address_pattern_corruption_checker_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload
// s         in         tdata[7:0] data_byte; tuser[0] first_byte
// m         out        tdata[31:0] event_position, [63:32] event_value; tuser[1:0] event_kind
// cfg       in         idx 0 region_size (31b), idx 1 separator_byte (8b)
//
// One byte per cycle sustained while the output is not stalled; a beat is checked
// while it sits in the input register, and its event (if any) then goes to the result register.
// All per-byte work is a single pass of add/compare logic on the running state.
// Reset is synchronous, active low; it clears state and config to defaults.
// A stalled output holds the input register, which then stalls the input.
module address_pattern_corruption_checker_top (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_tvalid,
    output logic                             o_s_tready,
    input  wire  [7:0]                       i_s_tdata,   // [7:0] data_byte
    input  wire  [0:0]                       i_s_tuser,   // [0] first_byte
    output logic                             o_m_tvalid,
    input  wire                              i_m_tready,
    output logic [63:0]                      o_m_tdata,   // [31:0] position, [63:32] value
    output logic [1:0]                       o_m_tuser,   // [1:0] event_kind
    input  wire                              i_cfg_we,
    input  wire  [apcc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire  [apcc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import apcc_pkg::*;

    // Configuration registers
    logic [REGION_W-1:0] r_region_size;
    logic [BYTE_W-1:0]   r_sep_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_size <= '0;
            r_sep_byte    <= SEP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REGION_SIZE: r_region_size <= i_cfg_data;
                CFG_SEPARATOR:   r_sep_byte    <= i_cfg_data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_data;
    logic              r_in_first;
    logic              r_out_valid;
    t_event            r_out_ev;
    logic              advance;
    logic              ev_valid;
    t_event            ev;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_data  <= i_s_tdata;
            r_in_first <= i_s_tuser[0];
        end
    end

    apcc_check u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (advance),
        .i_data        (r_in_data),
        .i_first       (r_in_first),
        .i_region_size (r_region_size),
        .i_sep_byte    (r_sep_byte),
        .o_ev_valid    (ev_valid),
        .o_ev          (ev)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= ev_valid;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && ev_valid) begin
            r_out_ev <= ev;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_ev.value, r_out_ev.position};
    assign o_m_tuser  = r_out_ev.kind;

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import apcc_pkg::*;

    // Pending input beat: data byte plus the start-of-region flag
    typedef struct packed {
        logic [7:0] data;
        logic       first;
    } t_beat;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [63:0]           m_tdata;
    logic [1:0]            m_tuser;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    address_pattern_corruption_checker_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),      // [7:0] data_byte
        .i_s_tuser  (s_tuser),      // [0] first_byte
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),      // [31:0] position, [63:32] value
        .o_m_tuser  (m_tuser),      // [1:0] event_kind
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_beat  pending_beats[$];
    t_event expected_events[$];

    // Shadow configuration
    logic [REGION_W-1:0] region_size_q = '0;
    logic [BYTE_W-1:0]   sep_q = SEP_RESET;

    // Shadow running state of the checker
    logic [31:0] word_acc = '0;
    logic [1:0]  word_fill = '0;
    logic [1:0]  sep_count = '0;
    t_status     seg_status = ST_CLEAN;
    logic [31:0] addr_offset = '0;
    logic [31:0] byte_addr = '0;

    // Stimulus bookkeeping
    logic        start_next = 1'b0;
    int unsigned region_pos = 0;
    int unsigned phase_beats = 0;
    logic        no_idle = 1'b0;
    logic        s_fire = 1'b0;

    int unsigned errors = 0;
    int unsigned beats_in = 0;
    int unsigned events_out = 0;
    int unsigned kind_count [3] = '{0, 0, 0};
    int unsigned settings_run = 1;
    int unsigned quiet_cycles = 0;

    // Advance the shadow checker by one byte and queue the event it causes
    task automatic track_byte(input logic [7:0] b, input logic first);
        logic [31:0] pos;
        logic [31:0] want;
        logic [2:0]  cnt;
        logic        sep_done;
        t_event      ev;
        if (first) begin
            word_acc    = '0;
            word_fill   = '0;
            sep_count   = '0;
            seg_status  = ST_CLEAN;
            addr_offset = '0;
            byte_addr   = '0;
        end
        pos      = byte_addr - 32'd3;
        word_acc = word_acc | ({24'd0, b} << (8 * word_fill));
        cnt      = {1'b0, word_fill} + 3'd1;
        sep_done = 1'b0;
        if (b == sep_q) begin
            if (sep_count == 2'd3) begin
                sep_done  = 1'b1;
                sep_count = '0;
            end else begin
                sep_count = sep_count + 2'd1;
            end
        end else begin
            sep_count = '0;
        end
        // separator word: restart assembly, close a corrupt segment
        if (sep_done) begin
            cnt      = '0;
            word_acc = '0;
            if (seg_status == ST_CORRUPT) begin
                ev = '{kind: EV_SEG_END, position: pos, value: 32'd0};
                expected_events.push_back(ev);
            end
            seg_status = ST_CLEAN;
        end
        // full word: compare against offset + position
        if (cnt == 3'd4) begin
            want = addr_offset + pos;
            if (word_acc != want) begin
                if (seg_status == ST_CLEAN && word_acc < {1'b0, region_size_q}) begin
                    addr_offset = word_acc - pos;
                    seg_status  = ST_MISALIGNED;
                    ev = '{kind: EV_MISALIGN, position: pos, value: word_acc};
                    expected_events.push_back(ev);
                end else if (seg_status != ST_CORRUPT) begin
                    seg_status = ST_CORRUPT;
                    ev = '{kind: EV_CORRUPT, position: pos, value: word_acc};
                    expected_events.push_back(ev);
                end
            end
            cnt      = '0;
            word_acc = '0;
        end
        word_fill = cnt[1:0];
        byte_addr = byte_addr + 32'd1;
    endtask

    // Monitor: sample both streams, check events, feed the shadow model
    always @(posedge i_clk) begin
        t_event ev;
        s_fire = i_rst_n && s_tvalid && s_tready;
        if (i_rst_n && m_tvalid && m_tready) begin
            events_out++;
            if (expected_events.size() == 0) begin
                errors++;
                $display("%0t: unexpected event kind %0d pos %h value %h",
                         $time, m_tuser, m_tdata[31:0], m_tdata[63:32]);
            end else begin
                ev = expected_events.pop_front();
                if (m_tuser < 2'd3) kind_count[m_tuser]++;
                if (m_tuser !== ev.kind) begin
                    errors++;
                    $display("%0t: event_kind expected %0d actual %0d",
                             $time, ev.kind, m_tuser);
                end
                if (m_tdata[31:0] !== ev.position) begin
                    errors++;
                    $display("%0t: event_position expected %h actual %h",
                             $time, ev.position, m_tdata[31:0]);
                end
                if (m_tdata[63:32] !== ev.value) begin
                    errors++;
                    $display("%0t: event_value expected %h actual %h",
                             $time, ev.value, m_tdata[63:32]);
                end
            end
        end
        if (s_fire) begin
            beats_in++;
            track_byte(s_tdata, s_tuser[0]);
        end
    end

    // Watchdog: give up when nothing moves for too long
    always @(posedge i_clk) begin
        if (s_fire || (m_tvalid && m_tready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= 3000) begin
            $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
            $display("testbench: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Input driver, fed from pending_beats
    always @(negedge i_clk) begin
        t_beat nxt;
        logic  idle;
        idle = !no_idle && ($urandom_range(0, 99) < 19);
        if (!s_tvalid || s_fire) begin
            if (pending_beats.size() > 0 && !idle) begin
                nxt = pending_beats.pop_front();
                s_tdata  <= nxt.data;
                s_tuser  <= nxt.first;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Output back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_idle || ($urandom_range(0, 99) >= 19);
        end
    end

    task automatic push_byte(input logic [7:0] b);
        if (start_next) region_pos = 0;
        pending_beats.push_back('{data: b, first: start_next});
        start_next = 1'b0;
        region_pos++;
        phase_beats++;
    endtask

    // Little-endian word, optionally only the first n bytes
    task automatic push_word(input logic [31:0] w, input int n);
        for (int k = 0; k < n; k++) push_byte(w[8*k +: 8]);
    endtask

    // Wait until all beats are in and all events are out, plus pipeline slack
    task automatic drain();
        while (pending_beats.size() > 0 || s_tvalid || expected_events.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [30:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_REGION_SIZE) region_size_q = val;
        else sep_q = val[7:0];
    endtask

    // One region: randomly chosen separator and address words with damage mixed in
    task automatic gen_region(input int words);
        logic [31:0] base;
        logic [31:0] w;
        int          sel;
        int          mode;
        sel = $urandom_range(0, 9);
        if (sel < 6) base = 32'd0;
        else if (sel < 8) base = $urandom_range(0, 32'h2000);
        else if (sel < 9) base = $urandom();
        else base = 32'hFFFF_FF00 + $urandom_range(0, 255);
        start_next = 1'b1;
        for (int k = 0; k < words; k++) begin
            w = ($urandom_range(0, 1) == 1) ? {4{sep_q}} : base + region_pos;
            mode = $urandom_range(0, 99);
            if (mode < 76) begin
                push_word(w, 4);
            end else if (mode < 83) begin
                w[8*$urandom_range(0, 3) +: 8] = 8'($urandom_range(0, 255));
                push_word(w, 4);
            end else if (mode < 88) begin
                push_word(w, 3);                 // dropped byte
            end else if (mode < 93) begin
                push_word(w, 4);
                push_byte(8'($urandom_range(0, 255))); // extra byte
            end else if (mode < 97) begin
                push_word($urandom(), 4);
            end else begin
                start_next = 1'b1;               // restart mid stream
                region_pos = 0;
                push_word(base, 4);
            end
        end
    endtask

    task automatic random_phase(input int target);
        int n;
        phase_beats = 0;
        while (phase_beats < target) begin
            if ($urandom_range(0, 99) < 85) begin
                gen_region($urandom_range(10, 60));
            end else begin
                n = $urandom_range(5, 30);
                for (int k = 0; k < n; k++) begin
                    start_next = ($urandom_range(0, 9) == 0);
                    push_byte(8'($urandom_range(0, 255)));
                end
            end
        end
        drain();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset config: clean words, corruption reported once, segment end
        start_next = 1'b1;
        push_word(32'd0, 4);
        push_word({4{SEP_RESET}}, 4);
        push_word(32'hFFFF_FFFF, 4);
        push_word(32'h1234_5678, 4);
        push_word({4{SEP_RESET}}, 4);
        drain();

        // Directed: misalignment guess, then a word that follows the new offset
        write_cfg(CFG_REGION_SIZE, 31'h100);
        write_cfg(CFG_SEPARATOR, 31'h0A5);
        settings_run++;
        start_next = 1'b1;
        push_word(32'h40, 4);
        push_word(32'h44, 4);
        push_word(32'hA5A5_A5A5, 4);
        push_word(32'h0000_0000, 4);
        drain();

        // Random phases over several settings, extremes first
        write_cfg(CFG_REGION_SIZE, 31'h7FFF_FFFF);
        write_cfg(CFG_SEPARATOR, 31'h0EF);
        settings_run++;
        random_phase(290);

        write_cfg(CFG_REGION_SIZE, 31'h0);
        write_cfg(CFG_SEPARATOR, 31'h000);
        settings_run++;
        random_phase(290);

        write_cfg(CFG_REGION_SIZE, 31'h1000);
        write_cfg(CFG_SEPARATOR, 31'h0FF);
        settings_run++;
        no_idle = 1'b1;
        random_phase(290);
        no_idle = 1'b0;

        write_cfg(CFG_REGION_SIZE, 31'($urandom_range(0, 32'h7FFF_FFFF)));
        write_cfg(CFG_SEPARATOR, 31'($urandom_range(0, 255)));
        settings_run++;
        random_phase(290);

        write_cfg(CFG_REGION_SIZE, 31'($urandom_range(0, 32'h4000)));
        write_cfg(CFG_SEPARATOR, 31'($urandom_range(0, 255)));
        settings_run++;
        random_phase(290);

        if (expected_events.size() > 0) begin
            errors++;
            $display("%0t: %0d events never arrived", $time, expected_events.size());
        end
        $display("run: %0d byte beats over %0d register settings, %0d events checked",
                 beats_in, settings_run, events_out);
        $display("run: segment end %0d, misalignment %0d, corruption %0d, mismatches %0d",
                 kind_count[0], kind_count[1], kind_count[2], errors);
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

[files.f]
hdl/apcc_pkg.sv
hdl/apcc_check.sv
hdl/address_pattern_corruption_checker_top.sv
bench/testbench.sv
